// ===== hdl/tets_pkg.sv =====
// shared types and constants of the timer event table scheduler
`timescale 1ns / 1ps
`default_nettype none
package tets_pkg;
  localparam int Entries = 16;
  localparam int MaxResults = 16;
  localparam int SlotW = $clog2(Entries);
  localparam int CntW = $clog2(MaxResults + 1);

  localparam logic [1:0] OP_POST   = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] KIND_STATUS   = 2'd0;
  localparam logic [1:0] KIND_QUERY    = 2'd1;
  localparam logic [1:0] KIND_DISPATCH = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADPRIO = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_NOROOM  = 2'd3;

  localparam logic REG_LOWEST_PRIO = 1'b0;
  localparam logic REG_MIN_DELAY   = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_id;
    logic [31:0] due_at;
    logic        relative;
    logic [7:0]  priority_req;
    logic [31:0] period;
    logic [31:0] argument;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        present;
    logic [7:0]  task_out;
    logic [7:0]  priority_out;
    logic [31:0] argument_out;
    logic        last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/timer_event_table_scheduler.sv =====
// timer event table scheduler top level
//
// One table slot is read per cycle through a single compare unit. After a
// post, cancel or query transfer busy stays high through the search pass and
// the single result appears in the first cycle with busy low. A tick adds a
// fire state and a further pass for every dispatch (at most MaxResults of
// them); each dispatch is held until the next search pass shows whether
// another follows, so it appears in the cycle after that pass ends and the
// last one in the first cycle with busy low. Results appear as single-cycle
// out_valid strobes that the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module timer_event_table_scheduler
  import tets_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DONE = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;

  logic [2:0]       state_r, state_nxt;
  logic [7:0]       lowp_r, mind_r;
  logic [31:0]      tick_r;
  logic [7:0]       etask_r [Entries];
  logic [Entries-1:0] fired_r;
  logic [31:0]      eft_m [Entries];
  logic [7:0]       epri_m [Entries];
  logic [31:0]      eper_m [Entries];
  logic [31:0]      earg_m [Entries];
  in_item_t         req_r;
  logic [31:0]      at_r;
  logic [SlotW:0]   idx_r;
  logic             found_r, free_ok_r;
  logic [SlotW-1:0] hit_r, free_r, best_r;
  logic             best_ok_r;
  logic [31:0]      bd_r;
  logic [CntW-1:0]  n_r;
  logic             outv_r;
  logic             pend_r;
  out_item_t        out_r;
  // registered memory read of the current slot
  logic [31:0]      rft_r;
  logic [SlotW-1:0] rslot_r;
  logic             rv_r;

  logic [SlotW-1:0] slot;
  logic [31:0]      delay;
  logic             armed;
  logic             fire_go;

  function automatic out_item_t make_out(logic [1:0] kind, logic [1:0] status,
                                         logic present, logic [7:0] tsk,
                                         logic [7:0] prio, logic [31:0] arg,
                                         logic lst);
    out_item_t r;
    r.kind = kind;
    r.status = status;
    r.present = present;
    r.task_out = tsk;
    r.priority_out = prio;
    r.argument_out = arg;
    r.last = lst;
    return r;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = outv_r;
  assign out_item  = out_r;
  assign slot      = idx_r[SlotW-1:0];
  assign armed     = (etask_r[rslot_r] != 8'd0);
  assign delay     = rft_r - tick_r;
  assign fire_go   = req_r.operation == OP_TICK && best_ok_r &&
                     $signed(bd_r) <= $signed({24'd0, mind_r}) &&
                     n_r != CntW'(MaxResults);

  always_ff @(posedge clk) begin
    rft_r   <= eft_m[slot];
    rslot_r <= slot;
    if (state_r == S_DONE && req_r.operation == OP_POST && !found_r && free_ok_r &&
        req_r.priority_req <= lowp_r && req_r.due_at != 32'd0 &&
        req_r.task_id != 8'd0) begin
      eft_m[free_r]  <= at_r;
      epri_m[free_r] <= req_r.priority_req;
      eper_m[free_r] <= req_r.period;
      earg_m[free_r] <= req_r.argument;
    end else if (state_r == S_DONE && req_r.operation == OP_POST && found_r &&
                 req_r.priority_req <= lowp_r && req_r.due_at != 32'd0 &&
                 epri_m[hit_r] == req_r.priority_req) begin
      eft_m[hit_r]  <= at_r;
      eper_m[hit_r] <= req_r.period;
    end else if (state_r == S_FIRE && eper_m[best_r] != 32'd0) begin
      eft_m[best_r] <= tick_r + eper_m[best_r];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_SCAN;
      S_SCAN: if (rv_r && rslot_r == SlotW'(Entries - 1)) state_nxt = S_DONE;
      S_DONE: state_nxt = fire_go ? S_FIRE : S_IDLE;
      S_FIRE: state_nxt = S_SCAN;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lowp_r  <= 8'd7;
      mind_r  <= 8'd2;
      tick_r  <= '0;
      outv_r  <= 1'b0;
      pend_r  <= 1'b0;
      rv_r    <= 1'b0;
      fired_r <= '0;
      for (int i = 0; i < Entries; i++) etask_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_LOWEST_PRIO) lowp_r <= cfg_data;
        else mind_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          rv_r   <= 1'b0;
          outv_r <= 1'b0;
          if (start) begin
            req_r     <= in_item;
            at_r      <= in_item.relative ? tick_r + in_item.due_at : in_item.due_at;
            idx_r     <= '0;
            found_r   <= 1'b0;
            free_ok_r <= 1'b0;
            best_ok_r <= 1'b0;
            n_r       <= '0;
            fired_r   <= '0;
            pend_r    <= 1'b0;
            if (in_item.operation == OP_TICK) tick_r <= tick_r + 32'd1;
          end
        end
        S_SCAN: begin
          outv_r <= 1'b0;
          if (!idx_r[SlotW] || Entries == 1) idx_r <= idx_r + 1'b1;
          rv_r <= 1'b1;
          if (rv_r) begin
            if (!armed && !free_ok_r) begin
              free_ok_r <= 1'b1;
              free_r    <= rslot_r;
            end
            if (armed && !found_r && etask_r[rslot_r] == req_r.task_id) begin
              found_r <= 1'b1;
              hit_r   <= rslot_r;
            end
            // earliest due, ties to lowest slot
            if (armed && !fired_r[rslot_r] &&
                (!best_ok_r || $signed(delay) < $signed(bd_r))) begin
              best_ok_r <= 1'b1;
              best_r    <= rslot_r;
              bd_r      <= delay;
            end
          end
        end
        S_DONE: begin
          rv_r  <= 1'b0;
          idx_r <= '0;
          case (req_r.operation)
            OP_POST: begin
              outv_r <= 1'b1;
              if (req_r.priority_req > lowp_r)
                out_r <= make_out(KIND_STATUS, ST_BADPRIO, 1'b0, req_r.task_id, 8'd0,
                                  32'd0, 1'b1);
              else if (req_r.due_at == 32'd0)
                out_r <= make_out(KIND_DISPATCH, ST_OK, 1'b0, req_r.task_id,
                                  req_r.priority_req, req_r.argument, 1'b1);
              else if (req_r.task_id == 8'd0)
                out_r <= make_out(KIND_STATUS, ST_PRESENT, 1'b0, req_r.task_id, 8'd0,
                                  32'd0, 1'b1);
              else if (found_r)
                out_r <= make_out(KIND_STATUS,
                                  (epri_m[hit_r] == req_r.priority_req) ? ST_OK : ST_PRESENT,
                                  1'b0, req_r.task_id, 8'd0, 32'd0, 1'b1);
              else if (free_ok_r) begin
                out_r <= make_out(KIND_STATUS, ST_OK, 1'b0, req_r.task_id, 8'd0,
                                  32'd0, 1'b1);
                etask_r[free_r] <= req_r.task_id;
              end else
                out_r <= make_out(KIND_STATUS, ST_NOROOM, 1'b0, req_r.task_id, 8'd0,
                                  32'd0, 1'b1);
            end
            OP_CANCEL: begin
              outv_r <= 1'b1;
              out_r  <= make_out(KIND_STATUS, found_r ? ST_OK : ST_PRESENT, 1'b0,
                                 req_r.task_id, 8'd0, 32'd0, 1'b1);
              if (found_r) etask_r[hit_r] <= 8'd0;
            end
            OP_QUERY: begin
              outv_r <= 1'b1;
              out_r  <= make_out(KIND_QUERY, ST_OK, found_r, req_r.task_id, 8'd0,
                                 32'd0, 1'b1);
            end
            default: begin
              // held dispatch goes out once the pass shows whether another follows
              outv_r <= pend_r;
              out_r  <= make_out(KIND_DISPATCH, ST_OK, 1'b0, out_r.task_out,
                                 out_r.priority_out, out_r.argument_out, !fire_go);
            end
          endcase
        end
        S_FIRE: begin
          outv_r    <= 1'b0;
          out_r     <= make_out(KIND_DISPATCH, ST_OK, 1'b0, etask_r[best_r],
                                epri_m[best_r], earg_m[best_r], 1'b0);
          pend_r    <= 1'b1;
          fired_r[best_r] <= 1'b1;
          n_r       <= n_r + 1'b1;
          best_ok_r <= 1'b0;
          if (eper_m[best_r] == 32'd0) etask_r[best_r] <= 8'd0;
        end
        default: outv_r <= 1'b0;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tets_checker.sv =====
// port-level checks of the scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module tets_checker
  import tets_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      out_valid,
  input wire out_item_t out_item,
  input wire logic      cfg_ready
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !busy) else $error("config ready while busy");
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.kind <= KIND_DISPATCH) else $error("bad kind");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_valid) else $error("result while idle");
endmodule
bind timer_event_table_scheduler tets_checker u_tets_checker (.*);
`default_nettype wire
